// ----- rtl/text_console_char_writer_assert.svh -----
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared assertion forms for the console checkers.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define TCCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define TCCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Geometry, codes and controller/datapath interface types of the console.
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 24;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CHAR_W  = 8;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

   typedef struct packed {
      logic accept;
      logic read_done;
      logic sweep;
   } tccw_cmd_type;

   typedef struct packed {
      logic rsp_full;
      logic is_read;
      logic is_clear;
      logic scrolls;
      logic sweep_last;
   } tccw_sts_type;

endpackage

// ----- rtl/tccw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: takes requests, waits out cell reads, runs blanking sweeps.
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   input  tccw_pkg::tccw_sts_type sts,
   output logic                   req_ready,
   output tccw_pkg::tccw_cmd_type cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_BLANK = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      req_ready     = (state_ff == S_IDLE) && (!sts.rsp_full || rsp_ready);
      cmd.accept    = req_valid && req_ready;
      cmd.read_done = (state_ff == S_READ);
      cmd.sweep     = (state_ff == S_CLEAR) || (state_ff == S_BLANK);
      state_in      = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept) begin
               priority if (sts.is_read) begin
                  state_in = S_READ;
               end else if (sts.is_clear) begin
                  state_in = S_CLEAR;
               end else if (sts.scrolls) begin
                  state_in = S_BLANK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         S_CLEAR, S_BLANK: begin
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/tccw_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_datapath
// Screen store with circular row base, cursor, sweep counter, result register.
// ----------------------------------------------------------------------------
module tccw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tccw_pkg::tccw_cmd_type              cmd,
   output tccw_pkg::tccw_sts_type              sts,
   input  logic [tccw_pkg::OP_W-1:0]           req_op,
   input  logic [tccw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [tccw_pkg::ROW_W-1:0]          req_read_row,
   input  logic [tccw_pkg::COL_W-1:0]          req_read_col,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [tccw_pkg::CHAR_W-1:0]         rsp_cell_char,
   output logic [tccw_pkg::ROW_W-1:0]          rsp_cur_row,
   output logic [tccw_pkg::COL_W-1:0]          rsp_cur_col
);

   // logical row -> physical row, with top_ff as the physical top row
   function automatic logic [tccw_pkg::ROW_W-1:0] phys_row(
      input logic [tccw_pkg::ROW_W-1:0] top,
      input logic [tccw_pkg::ROW_W-1:0] row
   );
      logic [tccw_pkg::ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS)) begin
         sum = sum - (tccw_pkg::ROW_W + 1)'(tccw_pkg::ROWS);
      end
      return sum[tccw_pkg::ROW_W-1:0];
   endfunction

   function automatic logic [tccw_pkg::ADDR_W-1:0] cell_addr(
      input logic [tccw_pkg::ROW_W-1:0] prow,
      input logic [tccw_pkg::COL_W-1:0] col
   );
      return tccw_pkg::ADDR_W'(prow) * tccw_pkg::ROW_STRIDE + tccw_pkg::ADDR_W'(col);
   endfunction

   logic [tccw_pkg::CHAR_W-1:0] mem [tccw_pkg::CELLS];

   logic [tccw_pkg::ROW_W-1:0]  row_ff, row_in, top_ff, top_in;
   logic [tccw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tccw_pkg::ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [tccw_pkg::ADDR_W-1:0] sweep_end_ff, sweep_end_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tccw_pkg::CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic [tccw_pkg::ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [tccw_pkg::COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [tccw_pkg::CHAR_W-1:0] rd_data_ff;
   logic                        rd_ok_ff, rd_ok_in;

   logic is_put, is_clear, is_read, is_lf, is_cr, is_wr;
   logic newline, at_last_row, scrolls;
   logic                        wr_en;
   logic [tccw_pkg::ADDR_W-1:0] wr_addr, rd_addr, top_addr;
   logic [tccw_pkg::CHAR_W-1:0] wr_data;

   always_comb begin
      is_put      = (req_op == tccw_pkg::OP_PUT);
      is_clear    = (req_op == tccw_pkg::OP_CLEAR);
      is_read     = (req_op == tccw_pkg::OP_READ);
      is_lf       = is_put && (req_char_code == tccw_pkg::CH_LF);
      is_cr       = is_put && (req_char_code == tccw_pkg::CH_CR);
      is_wr       = is_put && (req_char_code != tccw_pkg::CH_NUL) && !is_lf && !is_cr;
      newline     = is_lf || (is_wr && (col_ff == tccw_pkg::LAST_COL));
      at_last_row = (row_ff == tccw_pkg::LAST_ROW);
      scrolls     = newline && at_last_row;

      sts.rsp_full   = rsp_valid_ff;
      sts.is_read    = is_read;
      sts.is_clear   = is_clear;
      sts.scrolls    = scrolls;
      sts.sweep_last = (sweep_addr_ff == sweep_end_ff);

      rd_addr  = cell_addr(phys_row(top_ff, req_read_row), req_read_col);
      rd_ok_in = (req_read_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS)) &&
                 (req_read_col < tccw_pkg::COL_W'(tccw_pkg::COLUMNS));
      top_addr = cell_addr(top_ff, '0);

      if (cmd.sweep) begin
         wr_en   = 1'b1;
         wr_addr = sweep_addr_ff;
         wr_data = tccw_pkg::CH_SPACE;
      end else begin
         wr_en   = cmd.accept && is_wr;
         wr_addr = cell_addr(phys_row(top_ff, row_ff), col_ff);
         wr_data = req_char_code;
      end

      // cursor and row base
      row_in = row_ff;
      col_in = col_ff;
      top_in = top_ff;
      if (cmd.accept) begin
         priority if (is_clear) begin
            row_in = '0;
            col_in = '0;
            top_in = '0;
         end else if (newline) begin
            col_in = '0;
            if (at_last_row) begin
               top_in = (top_ff == tccw_pkg::LAST_ROW) ? '0 : top_ff + 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else if (is_cr) begin
            col_in = '0;
         end else if (is_wr) begin
            col_in = col_ff + 1'b1;
         end else begin
            col_in = col_ff;
         end
      end

      // blanking sweep: whole store on clear, old top row on scroll
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      if (cmd.accept && is_clear) begin
         sweep_addr_in = '0;
         sweep_end_in  = tccw_pkg::LAST_CELL;
      end else if (cmd.accept && scrolls) begin
         sweep_addr_in = top_addr;
         sweep_end_in  = top_addr + tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS - 1);
      end else if (cmd.sweep && !sts.sweep_last) begin
         sweep_addr_in = sweep_addr_ff + 1'b1;
      end

      // result register
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      if (cmd.read_done) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = rd_ok_ff ? rd_data_ff : '0;
         rsp_row_in   = row_ff;
         rsp_col_in   = col_ff;
      end else if (cmd.accept && !is_read) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = '0;
         rsp_row_in   = row_in;
         rsp_col_in   = col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= tccw_pkg::LAST_CELL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      if (cmd.accept) begin
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_char = rsp_char_ff;
   assign rsp_cur_row   = rsp_row_ff;
   assign rsp_cur_col   = rsp_col_ff;

endmodule

// ----- rtl/text_console_char_writer.sv -----
`timescale 1ns / 1ps
// Put, control codes and clear give their result in the cycle after the transfer; a read's result
// first passes the store read register. Throughput: 1 item per cycle for puts without scroll
// while results are taken; a read holds req_ready low until its result is loaded. A scroll blanks
// one row of the store, with req_ready low after the transfer until the sweep ends. A clear sweeps
// all 1920 cells alike. Reset (synchronous): cursor home, then a clear pass before the first item.
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console with wrap, line feed, carriage return and scroll.
// ----------------------------------------------------------------------------
module text_console_char_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tccw_pkg::OP_W-1:0]   req_op,
   input  logic [tccw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [tccw_pkg::ROW_W-1:0]  req_read_row,
   input  logic [tccw_pkg::COL_W-1:0]  req_read_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tccw_pkg::CHAR_W-1:0] rsp_cell_char,
   output logic [tccw_pkg::ROW_W-1:0]  rsp_cur_row,
   output logic [tccw_pkg::COL_W-1:0]  rsp_cur_col
);

   tccw_pkg::tccw_cmd_type cmd;
   tccw_pkg::tccw_sts_type sts;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   tccw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cur_row   (rsp_cur_row),
      .rsp_cur_col   (rsp_cur_col)
   );

endmodule

// ----- rtl/tccw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks of the console, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_console_char_writer_assert.svh"

module tccw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [tccw_pkg::OP_W-1:0]   req_op,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tccw_pkg::CHAR_W-1:0] rsp_cell_char,
   input logic [tccw_pkg::ROW_W-1:0]  rsp_cur_row,
   input logic [tccw_pkg::COL_W-1:0]  rsp_cur_col
);

   `TCCW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_char) && $stable(rsp_cur_row) && $stable(rsp_cur_col), "rsp transfer dropped or changed while stalled")

   `TCCW_ASSERT(a_cursor_range, clock, reset, rsp_valid |-> (rsp_cur_row < tccw_pkg::ROW_W'(tccw_pkg::ROWS)) && (rsp_cur_col < tccw_pkg::COL_W'(tccw_pkg::COLUMNS)), "cursor outside the screen")

   `TCCW_ASSERT(a_clear_home, clock, reset, req_valid && req_ready && (req_op == tccw_pkg::OP_CLEAR) |=> rsp_valid && (rsp_cur_row == '0) && (rsp_cur_col == '0) && (rsp_cell_char == '0), "clear did not home the cursor")

   `TCCW_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid && !req_ready, "activity right after reset")

endmodule

bind text_console_char_writer tccw_checker u_tccw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_op        (req_op),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_cell_char (rsp_cell_char),
   .rsp_cur_row   (rsp_cur_row),
   .rsp_cur_col   (rsp_cur_col)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_console_char_writer. Directed puts, control
// codes, reads, clears and the unused op come first. Random text lines
// follow, which wrap and scroll, mixed with reads and noise. Both channels
// idle at random. Every result is checked against a screen and cursor
// model kept in the bench.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [tccw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 10000;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      logic [tccw_pkg::CHAR_W-1:0] cell_char;
      logic [tccw_pkg::ROW_W-1:0]  cur_row;
      logic [tccw_pkg::COL_W-1:0]  cur_col;
   } console_view_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [tccw_pkg::OP_W-1:0]   req_op;
   logic [tccw_pkg::CHAR_W-1:0] req_char_code;
   logic [tccw_pkg::ROW_W-1:0]  req_read_row;
   logic [tccw_pkg::COL_W-1:0]  req_read_col;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [tccw_pkg::CHAR_W-1:0] rsp_cell_char;
   logic [tccw_pkg::ROW_W-1:0]  rsp_cur_row;
   logic [tccw_pkg::COL_W-1:0]  rsp_cur_col;

   logic [tccw_pkg::CHAR_W-1:0] screen_image [tccw_pkg::ROWS][tccw_pkg::COLUMNS];
   int                          cursor_line;
   int                          cursor_column;
   console_view_type            pending_views [$];
   int                          mismatches    = 0;
   int                          counted_items = 0;
   int                          idle_cycles   = 0;
   bit                          no_idle       = 1'b0;

   text_console_char_writer DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_char (rsp_cell_char),
      .rsp_cur_row   (rsp_cur_row),
      .rsp_cur_col   (rsp_cur_col)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic void blank_screen();
      for (int r = 0; r < tccw_pkg::ROWS; r++) begin
         for (int c = 0; c < tccw_pkg::COLUMNS; c++) begin
            screen_image[r][c] = tccw_pkg::CH_SPACE;
         end
      end
   endfunction

   function automatic void advance_line();
      cursor_column = 0;
      cursor_line++;
      if (cursor_line >= tccw_pkg::ROWS) begin
         for (int r = 0; r < tccw_pkg::ROWS - 1; r++) begin
            for (int c = 0; c < tccw_pkg::COLUMNS; c++) begin
               screen_image[r][c] = screen_image[r + 1][c];
            end
         end
         for (int c = 0; c < tccw_pkg::COLUMNS; c++) begin
            screen_image[tccw_pkg::ROWS - 1][c] = tccw_pkg::CH_SPACE;
         end
         cursor_line = tccw_pkg::ROWS - 1;
      end
   endfunction

   function automatic console_view_type console_step(
      input logic [tccw_pkg::OP_W-1:0]   op,
      input logic [tccw_pkg::CHAR_W-1:0] code,
      input logic [tccw_pkg::ROW_W-1:0]  row,
      input logic [tccw_pkg::COL_W-1:0]  col
   );
      console_view_type view;
      view.cell_char = '0;
      case (op)
         tccw_pkg::OP_PUT: begin
            if (code == tccw_pkg::CH_LF) begin
               advance_line();
            end else if (code == tccw_pkg::CH_CR) begin
               cursor_column = 0;
            end else if (code != tccw_pkg::CH_NUL) begin
               screen_image[cursor_line][cursor_column] = code;
               cursor_column++;
               if (cursor_column >= tccw_pkg::COLUMNS) begin
                  advance_line();
               end
            end
         end
         tccw_pkg::OP_CLEAR: begin
            blank_screen();
            cursor_line   = 0;
            cursor_column = 0;
         end
         tccw_pkg::OP_READ: begin
            if (row < tccw_pkg::ROWS && col < tccw_pkg::COLUMNS) begin
               view.cell_char = screen_image[row][col];
            end
         end
         default: ;
      endcase
      view.cur_row = tccw_pkg::ROW_W'(cursor_line);
      view.cur_col = tccw_pkg::COL_W'(cursor_column);
      return view;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [tccw_pkg::OP_W-1:0]   op,
                            input logic [tccw_pkg::CHAR_W-1:0] code,
                            input logic [tccw_pkg::ROW_W-1:0]  row,
                            input logic [tccw_pkg::COL_W-1:0]  col);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_char_code <= code;
      req_read_row  <= row;
      req_read_col  <= col;
      do @(posedge clock); while (!req_ready);
      pending_views.push_back(console_step(op, code, row, col));
      if (!((op == tccw_pkg::OP_PUT && code == tccw_pkg::CH_NUL) || op == OP_UNUSED)) begin
         counted_items++;
      end
   endtask

   task automatic send_put(input logic [tccw_pkg::CHAR_W-1:0] code);
      send_item(tccw_pkg::OP_PUT, code, tccw_pkg::ROW_W'($urandom),
                tccw_pkg::COL_W'($urandom));
   endtask

   task automatic send_read(input int row, input int col);
      send_item(tccw_pkg::OP_READ, tccw_pkg::CHAR_W'($urandom), tccw_pkg::ROW_W'(row),
                tccw_pkg::COL_W'(col));
   endtask

   // drop valid and hold off until every pending result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_views.size() != 0);
   endtask

   function automatic logic [tccw_pkg::CHAR_W-1:0] pick_text_char();
      if ($urandom_range(0, 9) == 0) begin
         return tccw_pkg::CHAR_W'($urandom_range(0, 255));
      end
      return tccw_pkg::CHAR_W'($urandom_range(8'h21, 8'h7E));
   endfunction

   task automatic send_text_line();
      int len;
      int r;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(75, 100) : $urandom_range(0, 15);
      repeat (len) send_put(pick_text_char());
      r = $urandom_range(0, 9);
      if (r < 2 || r == 8) begin
         send_put(tccw_pkg::CH_CR);
      end
      if (r < 8) begin
         send_put(tccw_pkg::CH_LF);
      end
   endtask

   task automatic send_random_read();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) begin
         send_read(cursor_line, $urandom_range(0, cursor_column));
      end else if (r < 6) begin
         send_read($urandom_range(0, tccw_pkg::ROWS - 1), $urandom_range(0, 15));
      end else if (r < 9) begin
         send_read($urandom_range(0, tccw_pkg::ROWS - 1),
                   $urandom_range(0, tccw_pkg::COLUMNS - 1));
      end else if ($urandom_range(0, 1) == 0) begin
         send_read($urandom_range(tccw_pkg::ROWS, 31), $urandom_range(0, 127));
      end else begin
         send_read($urandom_range(0, 31), $urandom_range(tccw_pkg::COLUMNS, 127));
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_put_and_read();
      send_put(8'h41);
      send_put(8'hFF);
      send_put(8'h01);
      send_put(tccw_pkg::CH_NUL);
      send_read(0, 0);
      send_read(0, 1);
      send_read(0, 2);
      send_read(0, 3);
   endtask

   task automatic test_control_codes();
      send_put(tccw_pkg::CH_CR);
      send_put(8'h5A);
      send_put(tccw_pkg::CH_LF);
      send_read(0, 0);
   endtask

   task automatic test_read_bounds();
      send_read(tccw_pkg::ROWS - 1, tccw_pkg::COLUMNS - 1);
      send_read(tccw_pkg::ROWS, 0);
      send_read(31, 127);
      send_read(0, tccw_pkg::COLUMNS);
   endtask

   task automatic test_unused_op();
      send_item(OP_UNUSED, 8'hFF, 5'h1F, 7'h7F);
      send_item(OP_UNUSED, 8'h00, 5'h00, 7'h00);
   endtask

   task automatic test_clear_home();
      send_item(tccw_pkg::OP_CLEAR, 8'hFF, 5'h1F, 7'h7F);
      send_read(0, 0);
      send_read(1, 0);
   endtask

   task automatic test_wrap_and_scroll();
      int target;
      target = counted_items + 200;
      while (counted_items < target) begin
         no_idle = ($urandom_range(0, 6) == 0);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) send_put(tccw_pkg::CH_LF);
         end else begin
            send_text_line();
         end
      end
   endtask

   task automatic test_random_traffic();
      int target;
      int r;
      target = counted_items + 230;
      while (counted_items < target) begin
         no_idle = ($urandom_range(0, 6) == 0);
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_text_line();
         end else if (r < 70) begin
            repeat ($urandom_range(1, 4)) send_random_read();
         end else if (r < 80) begin
            repeat ($urandom_range(1, 5)) send_put(tccw_pkg::CH_LF);
         end else if (r < 86) begin
            send_put(tccw_pkg::CH_NUL);
         end else if (r < 92) begin
            send_item(OP_UNUSED, tccw_pkg::CHAR_W'($urandom), tccw_pkg::ROW_W'($urandom),
                      tccw_pkg::COL_W'($urandom));
         end else if (r < 98) begin
            send_put(tccw_pkg::CHAR_W'($urandom_range(0, 255)));
         end else begin
            send_item(tccw_pkg::OP_CLEAR, tccw_pkg::CHAR_W'($urandom),
                      tccw_pkg::ROW_W'($urandom), tccw_pkg::COL_W'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------- checking
   function automatic void report_mismatch(input string            what,
                                           input console_view_type want,
                                           input console_view_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s): expected %02h %0d %0d, got %02h %0d %0d",
                  what, want.cell_char, want.cur_row, want.cur_col,
                  got.cell_char, got.cur_row, got.cur_col);
      end
   endfunction

   always @(posedge clock) begin
      console_view_type want;
      console_view_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_cell_char, rsp_cur_row, rsp_cur_col};
         if (pending_views.size() == 0) begin
            report_mismatch("result with nothing pending", '0, got);
         end else begin
            want = pending_views.pop_front();
            if (got.cell_char !== want.cell_char || got.cur_row !== want.cur_row ||
                got.cur_col !== want.cur_col) begin
               report_mismatch("field", want, got);
            end
         end
      end
   end

   // receiver side stalls
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= tccw_pkg::OP_PUT;
      req_char_code <= tccw_pkg::CH_NUL;
      req_read_row  <= '0;
      req_read_col  <= '0;
      blank_screen();
      cursor_line   = 0;
      cursor_column = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_put_and_read();
      test_control_codes();
      test_read_bounds();
      test_unused_op();
      test_clear_home();
      wait_drained();
      test_wrap_and_scroll();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_views.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
